/* design/tpa_pkg.sv */
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared types and constants of the two-pool free page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package tpa_pkg;

   localparam int SMALL_PAGES_DEF = 32768;
   localparam int SUPER_PAGES_DEF = 16;

   localparam int SMALL_SHIFT = 12;
   localparam int SUPER_SHIFT = 21;
   localparam int SMALL_PN_W  = 32 - SMALL_SHIFT;
   localparam int SUPER_PN_W  = 32 - SUPER_SHIFT;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] CMD_ALLOC_SMALL = 2'd0;
   localparam logic [1:0] CMD_FREE_SMALL  = 2'd1;
   localparam logic [1:0] CMD_ALLOC_SUPER = 2'd2;
   localparam logic [1:0] CMD_FREE_SUPER  = 2'd3;

   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   localparam logic [0:0] CSR_KERNEL_END = 1'b0;
   localparam logic [0:0] CSR_PHYS_TOP   = 1'b1;

   localparam logic [31:0] KERNEL_END_RST = 32'h8000_0000;
   localparam logic [31:0] PHYS_TOP_RST   = 32'h8800_0000;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic [31:0] page_address;
      logic [1:0]  status;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [1:0]            command;
      logic                  addr_ok;
      logic [SMALL_PN_W-1:0] page_num;
   } entry_type;

endpackage

`default_nettype wire

/* design/tpa_ram.sv */
// ----------------------------------------------------------------------------
// tpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/tpa_front.sv */
// ----------------------------------------------------------------------------
// tpa_front
// Configuration registers and address check; classifies each accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_front #(
   parameter int SUPER_PAGES = tpa_pkg::SUPER_PAGES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   input  wire logic [0:0]       csr_index,
   input  wire logic [31:0]      csr_data,
   input  wire tpa_pkg::req_type req_item,
   output tpa_pkg::entry_type    entry
);

   localparam logic [32:0] REGION    = 33'(SUPER_PAGES) << tpa_pkg::SUPER_SHIFT;
   localparam logic [32:0] SMALL_SZ  = 33'd1 << tpa_pkg::SMALL_SHIFT;
   localparam logic [32:0] SUPER_SZ  = 33'd1 << tpa_pkg::SUPER_SHIFT;

   logic [31:0] kernel_end_ff, kernel_end_in;
   logic [31:0] phys_top_ff, phys_top_in;
   logic [32:0] addr_x, top_x, super_base;
   logic        small_ok, super_ok;

   always_comb begin
      kernel_end_in = kernel_end_ff;
      phys_top_in   = phys_top_ff;
      if (csr_valid) begin
         case (csr_index)
            tpa_pkg::CSR_KERNEL_END: kernel_end_in = csr_data;
            tpa_pkg::CSR_PHYS_TOP:   phys_top_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_end_ff <= tpa_pkg::KERNEL_END_RST;
         phys_top_ff   <= tpa_pkg::PHYS_TOP_RST;
      end else begin
         kernel_end_ff <= kernel_end_in;
         phys_top_ff   <= phys_top_in;
      end
   end

   assign addr_x     = {1'b0, req_item.address};
   assign top_x      = {1'b0, phys_top_ff};
   assign super_base = (top_x >= REGION) ? (top_x - REGION) : 33'd0;

   assign small_ok = (req_item.address[tpa_pkg::SMALL_SHIFT-1:0] == '0)
                     && (req_item.address >= kernel_end_ff)
                     && ((addr_x + SMALL_SZ) <= top_x);

   assign super_ok = (req_item.address[tpa_pkg::SUPER_SHIFT-1:0] == '0)
                     && (addr_x >= super_base)
                     && ((addr_x + SUPER_SZ) <= top_x);

   always_comb begin
      entry.command  = req_item.command;
      entry.addr_ok  = (req_item.command == tpa_pkg::CMD_FREE_SUPER) ? super_ok : small_ok;
      entry.page_num = req_item.address[31:tpa_pkg::SMALL_SHIFT];
   end

endmodule

`default_nettype wire

/* design/tpa_queue.sv */
// ----------------------------------------------------------------------------
// tpa_queue
// Short first-in-first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tpa_pkg::entry_type push_entry,
   input  wire logic               pop,
   output tpa_pkg::entry_type      pop_entry,
   output logic                    not_empty,
   output logic                    full
);

   localparam int PW = $clog2(tpa_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(tpa_pkg::QUEUE_DEPTH + 1);

   tpa_pkg::entry_type slot_ff [tpa_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CW'(tpa_pkg::QUEUE_DEPTH));
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* design/tpa_back.sv */
// ----------------------------------------------------------------------------
// tpa_back
// Pool stacks and counters; carries out one classified item per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_back #(
   parameter int SMALL_PAGES = tpa_pkg::SMALL_PAGES_DEF,
   parameter int SUPER_PAGES = tpa_pkg::SUPER_PAGES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire tpa_pkg::entry_type item,
   output logic                    rsp_strobe,
   output tpa_pkg::rsp_type        rsp_item
);

   localparam int SMALL_IW = (SMALL_PAGES > 1) ? $clog2(SMALL_PAGES) : 1;
   localparam int SUPER_IW = (SUPER_PAGES > 1) ? $clog2(SUPER_PAGES) : 1;
   localparam int SMALL_CW = $clog2(SMALL_PAGES + 1);
   localparam int SUPER_CW = $clog2(SUPER_PAGES + 1);

   logic [SMALL_CW-1:0] small_count_ff, small_count_in, small_dec;
   logic [SUPER_CW-1:0] super_count_ff, super_count_in, super_dec;

   logic                        small_wr, small_rd, super_wr, super_rd;
   logic [tpa_pkg::SMALL_PN_W-1:0] small_rdata;
   logic [tpa_pkg::SUPER_PN_W-1:0] super_rdata;

   logic       out_valid_ff, out_valid_in;
   logic [1:0] out_status_ff, out_status_in;
   logic       out_small_ff, out_small_in;
   logic       out_super_ff, out_super_in;

   assign small_dec = small_count_ff - SMALL_CW'(1);
   assign super_dec = super_count_ff - SUPER_CW'(1);

   always_comb begin
      small_count_in = small_count_ff;
      super_count_in = super_count_ff;
      small_wr       = 1'b0;
      small_rd       = 1'b0;
      super_wr       = 1'b0;
      super_rd       = 1'b0;
      out_valid_in   = item_valid;
      out_status_in  = tpa_pkg::ST_DONE;
      out_small_in   = 1'b0;
      out_super_in   = 1'b0;
      if (item_valid) begin
         case (item.command)
            tpa_pkg::CMD_ALLOC_SMALL: begin
               if (small_count_ff == '0) begin
                  out_status_in = tpa_pkg::ST_EMPTY;
               end else begin
                  small_rd       = 1'b1;
                  out_small_in   = 1'b1;
                  small_count_in = small_dec;
               end
            end
            tpa_pkg::CMD_FREE_SMALL: begin
               if (!item.addr_ok) begin
                  out_status_in = tpa_pkg::ST_REJECT;
               end else if (small_count_ff == SMALL_CW'(SMALL_PAGES)) begin
                  out_status_in = tpa_pkg::ST_FULL;
               end else begin
                  small_wr       = 1'b1;
                  small_count_in = small_count_ff + SMALL_CW'(1);
               end
            end
            tpa_pkg::CMD_ALLOC_SUPER: begin
               if (super_count_ff == '0) begin
                  out_status_in = tpa_pkg::ST_EMPTY;
               end else begin
                  super_rd       = 1'b1;
                  out_super_in   = 1'b1;
                  super_count_in = super_dec;
               end
            end
            default: begin
               if (!item.addr_ok) begin
                  out_status_in = tpa_pkg::ST_REJECT;
               end else if (super_count_ff == SUPER_CW'(SUPER_PAGES)) begin
                  out_status_in = tpa_pkg::ST_FULL;
               end else begin
                  super_wr       = 1'b1;
                  super_count_in = super_count_ff + SUPER_CW'(1);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         small_count_ff <= '0;
         super_count_ff <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         small_count_ff <= small_count_in;
         super_count_ff <= super_count_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_small_ff  <= out_small_in;
      out_super_ff  <= out_super_in;
   end

   tpa_ram #(
      .WIDTH (tpa_pkg::SMALL_PN_W),
      .DEPTH (SMALL_PAGES)
   ) u_small_ram (
      .clock   (clock),
      .wr_en   (small_wr),
      .wr_addr (small_count_ff[SMALL_IW-1:0]),
      .wr_data (item.page_num),
      .rd_en   (small_rd),
      .rd_addr (small_dec[SMALL_IW-1:0]),
      .rd_data (small_rdata)
   );

   tpa_ram #(
      .WIDTH (tpa_pkg::SUPER_PN_W),
      .DEPTH (SUPER_PAGES)
   ) u_super_ram (
      .clock   (clock),
      .wr_en   (super_wr),
      .wr_addr (super_count_ff[SUPER_IW-1:0]),
      .wr_data (item.page_num[tpa_pkg::SMALL_PN_W-1:tpa_pkg::SMALL_PN_W-tpa_pkg::SUPER_PN_W]),
      .rd_en   (super_rd),
      .rd_addr (super_dec[SUPER_IW-1:0]),
      .rd_data (super_rdata)
   );

   always_comb begin
      rsp_strobe      = out_valid_ff;
      rsp_item.status = out_status_ff;
      if (out_small_ff) begin
         rsp_item.page_address = {small_rdata, {tpa_pkg::SMALL_SHIFT{1'b0}}};
      end else if (out_super_ff) begin
         rsp_item.page_address = {super_rdata, {tpa_pkg::SUPER_SHIFT{1'b0}}};
      end else begin
         rsp_item.page_address = '0;
      end
   end

endmodule

`default_nettype wire

/* design/two_pool_free_page_allocator_core.sv */
// ----------------------------------------------------------------------------
// two_pool_free_page_allocator_core
// Two last-in-first-out pools of free 4 KiB pages and 2 MiB superpages.
// ----------------------------------------------------------------------------
// One item is taken per cycle. Its result is on rsp_item with rsp_strobe,
// which is high for a single cycle: the item passes through the front queue,
// and the registered stack RAM read is loaded at the same edge as the status.
// The back end retires one item every cycle and the receiver cannot stall, so
// the queue never holds more than one item and busy stays low. Configuration
// writes are taken at any time (csr_ready stays high).
`default_nettype none

module two_pool_free_page_allocator_core #(
   parameter int SMALL_PAGES = tpa_pkg::SMALL_PAGES_DEF,
   parameter int SUPER_PAGES = tpa_pkg::SUPER_PAGES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire tpa_pkg::req_type req_item,
   output logic                  rsp_strobe,
   output tpa_pkg::rsp_type      rsp_item,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [0:0]       csr_index,
   input  wire logic [31:0]      csr_data
);

   tpa_pkg::entry_type front_entry;
   tpa_pkg::entry_type back_entry;
   logic               q_not_empty;
   logic               q_full;
   logic               accept;

   assign csr_ready = 1'b1;
   assign busy      = q_full;
   assign accept    = start && !q_full;

   tpa_front #(
      .SUPER_PAGES (SUPER_PAGES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_item  (req_item),
      .entry     (front_entry)
   );

   tpa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (front_entry),
      .pop        (q_not_empty),
      .pop_entry  (back_entry),
      .not_empty  (q_not_empty),
      .full       (q_full)
   );

   tpa_back #(
      .SMALL_PAGES (SMALL_PAGES),
      .SUPER_PAGES (SUPER_PAGES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_not_empty),
      .item       (back_entry),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-pool free page allocator core. Commands are
// sent through the start/busy port with random idle bursts, and the window
// registers are reprogrammed between phases. The phases cover reset values,
// extreme windows and random windows, and one phase fills the superpage pool
// to its limit. A scoreboard tracks both page stacks and the window registers,
// works out the status and page of every accepted command and checks them
// against the results in order.
// ----------------------------------------------------------------------------
module tb;
   import tpa_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;

   class pool_scoreboard;
      logic [31:0]           kernel_end;
      logic [31:0]           phys_top;
      logic [SMALL_PN_W-1:0] small_pool[$];
      logic [SUPER_PN_W-1:0] super_pool[$];
      rsp_type               awaited_rsp[$];
      int                    errors;

      function new();
         kernel_end = KERNEL_END_RST;
         phys_top   = PHYS_TOP_RST;
         errors     = 0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) begin
            $display("%0t: %s", $realtime, msg);
         end
      endfunction

      function bit small_fits(logic [31:0] a);
         return a[SMALL_SHIFT-1:0] == '0 && a >= kernel_end
            && ({1'b0, a} + (33'd1 << SMALL_SHIFT)) <= {1'b0, phys_top};
      endfunction

      function bit super_fits(logic [31:0] a);
         logic [32:0] region;
         logic [32:0] base;
         region = 33'(SUPER_PAGES_DEF) << SUPER_SHIFT;
         base   = ({1'b0, phys_top} >= region) ? {1'b0, phys_top} - region : '0;
         return a[SUPER_SHIFT-1:0] == '0 && {1'b0, a} >= base
            && ({1'b0, a} + (33'd1 << SUPER_SHIFT)) <= {1'b0, phys_top};
      endfunction

      function rsp_type apply_command(req_type r);
         rsp_type res;
         res.page_address = '0;
         res.status       = ST_DONE;
         case (r.command)
            CMD_ALLOC_SMALL: begin
               if (small_pool.size() == 0) res.status = ST_EMPTY;
               else res.page_address = {small_pool.pop_back(), {SMALL_SHIFT{1'b0}}};
            end
            CMD_FREE_SMALL: begin
               if (!small_fits(r.address)) res.status = ST_REJECT;
               else if (small_pool.size() >= SMALL_PAGES_DEF) res.status = ST_FULL;
               else small_pool.push_back(r.address[31:SMALL_SHIFT]);
            end
            CMD_ALLOC_SUPER: begin
               if (super_pool.size() == 0) res.status = ST_EMPTY;
               else res.page_address = {super_pool.pop_back(), {SUPER_SHIFT{1'b0}}};
            end
            default: begin
               if (!super_fits(r.address)) res.status = ST_REJECT;
               else if (super_pool.size() >= SUPER_PAGES_DEF) res.status = ST_FULL;
               else super_pool.push_back(r.address[31:SUPER_SHIFT]);
            end
         endcase
         return res;
      endfunction

      function void note_command(req_type r);
         awaited_rsp.push_back(apply_command(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited_rsp.size() == 0) begin
            flag($sformatf("unexpected item: page %h status %0d",
                           got.page_address, got.status));
            return;
         end
         want = awaited_rsp.pop_front();
         if (got.page_address !== want.page_address || got.status !== want.status) begin
            flag($sformatf("mismatch: page exp %h got %h, status exp %0d got %0d",
                           want.page_address, got.page_address, want.status, got.status));
         end
      endfunction

      function void close_out();
         if (awaited_rsp.size() != 0) begin
            flag($sformatf("%0d items never came out", awaited_rsp.size()));
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_item;
   logic        rsp_strobe;
   rsp_type     rsp_item;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [31:0] csr_data;

   pool_scoreboard sb;
   int cycle_count = 0;
   int idle_pct    = 20;
   bit calm        = 1'b0;

   two_pool_free_page_allocator_core DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_command(req_item);
         if (rsp_strobe) sb.check_result(rsp_item);
      end
   end

   // valid page inside the window most of the time, else an edge or noise
   function automatic logic [31:0] small_addr(bit want_ok);
      longint lo;
      longint hi;
      lo = longint'(({32'd0, sb.kernel_end} + 64'd4095) >> SMALL_SHIFT);
      hi = longint'({32'd0, sb.phys_top} >> SMALL_SHIFT) - 1;
      if (lo <= hi && (want_ok || $urandom_range(0, 99) < 65)) begin
         return 32'((lo + $urandom_range(0, int'(hi - lo))) << SMALL_SHIFT);
      end
      case ($urandom_range(0, 6))
         0: return sb.kernel_end;
         1: return sb.kernel_end - 32'h1000;
         2: return sb.phys_top - 32'h1000;
         3: return sb.phys_top;
         4: return $urandom;
         5: return ($urandom & 32'hFFFF_F000) | $urandom_range(1, 32'hFFF);
         default: return $urandom & 32'hFFFF_F000;
      endcase
   endfunction

   function automatic logic [31:0] super_addr(bit want_ok);
      logic [32:0] region;
      logic [32:0] base;
      longint      lo;
      longint      hi;
      region = 33'(SUPER_PAGES_DEF) << SUPER_SHIFT;
      base   = ({1'b0, sb.phys_top} >= region) ? {1'b0, sb.phys_top} - region : '0;
      lo     = longint'((base + 33'h1F_FFFF) >> SUPER_SHIFT);
      hi     = longint'({1'b0, sb.phys_top} >> SUPER_SHIFT) - 1;
      if (lo <= hi && (want_ok || $urandom_range(0, 99) < 65)) begin
         return 32'((lo + $urandom_range(0, int'(hi - lo))) << SUPER_SHIFT);
      end
      case ($urandom_range(0, 6))
         0: return 32'(base);
         1: return 32'(base) - 32'h0020_0000;
         2: return sb.phys_top - 32'h0020_0000;
         3: return sb.phys_top;
         4: return $urandom;
         5: return ($urandom & 32'hFFE0_0000) | $urandom_range(1, 32'h1F_FFFF);
         default: return $urandom & 32'hFFE0_0000;
      endcase
   endfunction

   task automatic send(input logic [1:0] cmd, input logic [31:0] addr);
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         start    <= 1'b0;
         req_item <= '{command: 2'($urandom), address: $urandom};
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= '{command: cmd, address: addr};
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic send_random();
      int r;
      r = $urandom_range(0, 99);
      if (r < 22) send(CMD_ALLOC_SMALL, $urandom);
      else if (r < 52) send(CMD_FREE_SMALL, small_addr(1'b0));
      else if (r < 72) send(CMD_ALLOC_SUPER, $urandom);
      else send(CMD_FREE_SUPER, super_addr(1'b0));
   endtask

   task automatic run_random(input int n, input int idle);
      idle_pct = idle;
      repeat (n) send_random();
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (sb.awaited_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_window(input logic [31:0] ke, input logic [31:0] pt);
      csr_valid <= 1'b1;
      csr_index <= CSR_KERNEL_END;
      csr_data  <= ke;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      sb.kernel_end = ke;
      csr_index <= CSR_PHYS_TOP;
      csr_data  <= pt;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      sb.phys_top = pt;
      csr_valid <= 1'b0;
   endtask

   // reset window: pages 0x80000000..0x87fff000, superpages from 0x86000000
   task automatic run_directed();
      send(CMD_ALLOC_SMALL, 32'hFFFF_FFFF);
      send(CMD_ALLOC_SUPER, 32'hFFFF_FFFF);
      send(CMD_FREE_SMALL, 32'h8000_0000);
      send(CMD_FREE_SMALL, 32'h87FF_F000);
      send(CMD_FREE_SMALL, 32'h8800_0000);
      send(CMD_FREE_SMALL, 32'h7FFF_F000);
      send(CMD_FREE_SMALL, 32'h8000_0800);
      send(CMD_FREE_SMALL, 32'h0000_0000);
      send(CMD_FREE_SMALL, 32'hFFFF_FFFF);
      send(CMD_FREE_SMALL, 32'hFFFF_F000);
      send(CMD_ALLOC_SMALL, 32'h0000_0000);
      send(CMD_FREE_SMALL, 32'h8000_0000);
      repeat (3) send(CMD_ALLOC_SMALL, 32'h0000_0000);
      send(CMD_FREE_SUPER, 32'h8600_0000);
      send(CMD_FREE_SUPER, 32'h87E0_0000);
      send(CMD_FREE_SUPER, 32'h85E0_0000);
      send(CMD_FREE_SUPER, 32'h8610_0000);
      send(CMD_FREE_SUPER, 32'h8800_0000);
      send(CMD_FREE_SUPER, 32'hFFE0_0000);
      repeat (3) send(CMD_ALLOC_SUPER, 32'h0000_0000);
   endtask

   initial begin
      logic [31:0] rand_ke;
      longint      rand_top;
      sb        = new();
      reset     = 1'b1;
      start     = 1'b0;
      req_item  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_KERNEL_END;
      csr_data  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      settle();
      set_window(32'h0000_0000, 32'hFFFF_FFFF);
      run_random(300, 30);

      settle();
      set_window(32'hFFFF_FFFF, 32'h0000_0000);
      run_random(60, 0);

      // top below the superpage region size, so the region starts at zero
      settle();
      set_window(32'h0040_0000, 32'h0100_0000);
      run_random(250, 50);

      repeat (4) begin
         settle();
         rand_ke  = ($urandom_range(0, 2) == 0) ? $urandom : ($urandom & 32'hFFFF_F000);
         rand_top = longint'({32'd0, rand_ke}) + $urandom_range(0, 32'h0600_0000);
         set_window(rand_ke, (rand_top > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(rand_top));
         run_random(150, $urandom_range(0, 60));
      end

      // fill the superpage pool to its limit at the reset window
      settle();
      set_window(KERNEL_END_RST, PHYS_TOP_RST);
      idle_pct = 2;
      send(CMD_FREE_SMALL, sb.kernel_end | 32'h0000_0800);
      while (sb.super_pool.size() < SUPER_PAGES_DEF) send(CMD_FREE_SUPER, super_addr(1'b1));
      repeat (2) send(CMD_FREE_SUPER, super_addr(1'b1));
      send(CMD_FREE_SUPER, sb.phys_top);

      calm = 1'b1;
      run_random(300, 0);

      settle();
      repeat (16) @(posedge clock);
      sb.close_out();
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
design/tpa_pkg.sv
design/tpa_ram.sv
design/tpa_front.sv
design/tpa_queue.sv
design/tpa_back.sv
design/two_pool_free_page_allocator_core.sv
tb/tb.sv
